[src/ecse_pkg.sv]
package ecse_pkg;

  localparam int unsigned SIDE_W  = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned IDX_W   = 21;
  localparam int unsigned VAL_W   = 52;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned NUM_ENT = 10;

  typedef enum logic [CFG_A_W-1:0] {
    REG_GRID_WIDTH     = 3'd0,
    REG_GRID_HEIGHT    = 3'd1,
    REG_INV_HX_SQUARED = 3'd2,
    REG_INV_HY_SQUARED = 3'd3,
    REG_INV_FOUR_HX_HY = 3'd4
  } cfg_reg_t;

  localparam logic [SIDE_W-1:0] RST_GRID_WIDTH     = 11'd64;
  localparam logic [SIDE_W-1:0] RST_GRID_HEIGHT    = 11'd64;
  localparam logic [COEF_W-1:0] RST_INV_HX_SQUARED = 24'd4096;
  localparam logic [COEF_W-1:0] RST_INV_HY_SQUARED = 24'd4096;
  localparam logic [COEF_W-1:0] RST_INV_FOUR_HX_HY = 24'd1024;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // Neighbour flags of one point, carried down the pipeline with the data.
  typedef struct packed {
    logic down;
    logic up;
    logic right;
    logic left;
  } nbr_t;

endpackage

[src/ecse_ifs.sv]
interface ecse_in_if;
  logic                          valid;
  logic                          ready;
  logic [ecse_pkg::POS_W-1:0]    point_col;
  logic [ecse_pkg::POS_W-1:0]    point_row;
  logic [ecse_pkg::COEF_W-1:0]   shear_mu;
  logic [ecse_pkg::COEF_W-1:0]   lame_lambda;

  modport source (output valid, point_col, point_row, shear_mu, lame_lambda, input ready);
  modport sink   (input valid, point_col, point_row, shear_mu, lame_lambda, output ready);
endinterface

interface ecse_out_if;
  logic                          valid;
  logic                          ready;
  logic [ecse_pkg::IDX_W-1:0]    matrix_row;
  logic [ecse_pkg::IDX_W-1:0]    matrix_col;
  logic signed [ecse_pkg::VAL_W-1:0] coeff_value;
  logic                          last_entry;

  modport source (output valid, matrix_row, matrix_col, coeff_value, last_entry, input ready);
  modport sink   (input valid, matrix_row, matrix_col, coeff_value, last_entry, output ready);
endinterface

interface ecse_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ecse_pkg::CFG_A_W-1:0]  reg_index;
  logic [ecse_pkg::COEF_W-1:0]   write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

[src/elasticity_stencil_coeff_emitter.sv]
// Channel   Dir  Role                                   Payload
// in_ch     in   grid point request                     point_col, point_row, shear_mu, lame_lambda
// out_ch    out  matrix entry, one per cycle when ready matrix_row, matrix_col, coeff_value, last_entry
// cfg_ch    in   register write, always ready           reg_index, write_data
//
// A point passes two pipeline stages, then a serializer that feeds the output register.
// The serializer drains one entry per cycle, while out_ch is not stalled, through the single
// output port; a point has 2 to 10 entries, and a point outside the grid is dropped in stage 1.
// Reset (rst_n low, synchronous) empties every stage and loads the register defaults.
// A stall on out_ch holds the output register and backs up stage by stage; nothing drops.
module elasticity_stencil_coeff_emitter #(
  parameter int unsigned MAX_GRID_SIDE = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  ecse_in_if.sink    in_ch,
  ecse_out_if.source out_ch,
  ecse_cfg_if.sink   cfg_ch
);

  localparam logic [12:0] MAX_SIDE = 13'(MAX_GRID_SIDE);

  // Configuration registers
  logic [ecse_pkg::SIDE_W-1:0] grid_width_r, grid_height_r;
  logic [ecse_pkg::COEF_W-1:0] inv_hx_sq_r, inv_hy_sq_r, inv_4hxhy_r;
  logic [ecse_pkg::SIDE_W-1:0] w, h;
  ecse_pkg::idx_t              total_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= ecse_pkg::RST_GRID_WIDTH;
      grid_height_r <= ecse_pkg::RST_GRID_HEIGHT;
      inv_hx_sq_r   <= ecse_pkg::RST_INV_HX_SQUARED;
      inv_hy_sq_r   <= ecse_pkg::RST_INV_HY_SQUARED;
      inv_4hxhy_r   <= ecse_pkg::RST_INV_FOUR_HX_HY;
    end else if (cfg_ch.valid) begin
      case (ecse_pkg::cfg_reg_t'(cfg_ch.reg_index))
        ecse_pkg::REG_GRID_WIDTH:     grid_width_r  <= cfg_ch.write_data[ecse_pkg::SIDE_W-1:0];
        ecse_pkg::REG_GRID_HEIGHT:    grid_height_r <= cfg_ch.write_data[ecse_pkg::SIDE_W-1:0];
        ecse_pkg::REG_INV_HX_SQUARED: inv_hx_sq_r   <= cfg_ch.write_data;
        ecse_pkg::REG_INV_HY_SQUARED: inv_hy_sq_r   <= cfg_ch.write_data;
        ecse_pkg::REG_INV_FOUR_HX_HY: inv_4hxhy_r   <= cfg_ch.write_data;
        default: ;
      endcase
    end
  end

  // Saturate the sides to the largest supported grid.
  assign w = ({2'b00, grid_width_r}  > MAX_SIDE) ? MAX_SIDE[ecse_pkg::SIDE_W-1:0] : grid_width_r;
  assign h = ({2'b00, grid_height_r} > MAX_SIDE) ? MAX_SIDE[ecse_pkg::SIDE_W-1:0] : grid_height_r;

  // Offset of the v block; registered from w and h, it settles long before a point needs it.
  always_ff @(posedge clk) begin
    total_r <= ecse_pkg::IDX_W'({11'b0, w} * {11'b0, h});
  end

  // Stage handshake chain
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_en, s2_en, ser_take, out_load;
  logic [ecse_pkg::NUM_ENT-1:0] ser_mask_r, ser_mask_nxt;
  logic ser_single, ser_busy;

  assign ser_busy   = (ser_mask_r != '0);
  assign ser_single = ser_busy && ((ser_mask_r & (ser_mask_r - 1'b1)) == '0);
  assign out_load   = !out_v_r || out_ch.ready;
  assign ser_take   = !ser_busy || (out_load && ser_single);
  assign s2_en      = !s2_v_r || ser_take;
  assign s1_en      = !s1_v_r || s2_en;
  assign in_ch.ready = s1_en;

  // Stage 1: bounds, neighbour flags and coefficient sums
  logic [ecse_pkg::POS_W-1:0]  s1_i_r, s1_j_r;
  logic [ecse_pkg::COEF_W-1:0] s1_mu_r;
  logic [25:0]                 s1_tml_r;
  logic [24:0]                 s1_lpm_r;
  ecse_pkg::nbr_t              s1_nbr_r, nbr_in;
  logic                        on_grid;

  assign on_grid      = ({1'b0, in_ch.point_col} < w) && ({1'b0, in_ch.point_row} < h);
  assign nbr_in.down  = ({1'b0, in_ch.point_row} + 11'd1) < h;
  assign nbr_in.up    = (in_ch.point_row != '0);
  assign nbr_in.right = ({1'b0, in_ch.point_col} + 11'd1) < w;
  assign nbr_in.left  = (in_ch.point_col != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      // Drop a point outside the grid here: it has no entries.
      s1_v_r <= in_ch.valid && on_grid;
    end
    if (s1_en) begin
      s1_i_r   <= in_ch.point_col;
      s1_j_r   <= in_ch.point_row;
      s1_mu_r  <= in_ch.shear_mu;
      s1_tml_r <= {1'b0, in_ch.shear_mu, 1'b0} + {2'b00, in_ch.lame_lambda};
      s1_lpm_r <= {1'b0, in_ch.shear_mu} + {1'b0, in_ch.lame_lambda};
      s1_nbr_r <= nbr_in;
    end
  end

  // Stage 2: the five scaled coefficients and the point's u index
  logic [49:0]    s2_a_r, s2_d_r;
  logic [47:0]    s2_b_r, s2_c_r;
  logic [48:0]    s2_e_r;
  ecse_pkg::idx_t s2_here_r;
  ecse_pkg::nbr_t s2_nbr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_en) begin
      s2_a_r    <= s1_tml_r * inv_hx_sq_r;
      s2_b_r    <= s1_mu_r * inv_hy_sq_r;
      s2_c_r    <= s1_mu_r * inv_hx_sq_r;
      s2_d_r    <= s1_tml_r * inv_hy_sq_r;
      s2_e_r    <= s1_lpm_r * inv_4hxhy_r;
      s2_here_r <= ecse_pkg::IDX_W'({11'b0, s1_j_r} * {10'b0, w}) + ecse_pkg::IDX_W'(s1_i_r);
      s2_nbr_r  <= s1_nbr_r;
    end
  end

  // Stage 3 build: all ten entries of the point, with an existence mask
  ecse_pkg::idx_t u_idx, v_idx, wx;
  ecse_pkg::idx_t col_in [ecse_pkg::NUM_ENT];
  ecse_pkg::val_t val_in [ecse_pkg::NUM_ENT];
  ecse_pkg::val_t pos_e, neg_e;
  logic [ecse_pkg::NUM_ENT-1:0] mask_in;

  always_comb begin
    u_idx = s2_here_r;
    v_idx = total_r + s2_here_r;
    wx    = ecse_pkg::IDX_W'(w);
    pos_e = ecse_pkg::VAL_W'(s2_e_r);
    neg_e = ecse_pkg::VAL_W'(0) - pos_e;

    col_in[0] = u_idx;
    col_in[1] = v_idx;
    col_in[2] = u_idx + wx;
    col_in[3] = v_idx + wx;
    col_in[4] = u_idx + 1'b1;
    col_in[5] = v_idx + 1'b1;
    col_in[6] = v_idx + wx + 1'b1;
    col_in[7] = v_idx - wx + 1'b1;
    col_in[8] = v_idx + wx - 1'b1;
    col_in[9] = v_idx - wx - 1'b1;

    val_in[0] = ecse_pkg::VAL_W'(0) - (ecse_pkg::VAL_W'(s2_a_r) + ecse_pkg::VAL_W'(s2_b_r));
    val_in[1] = ecse_pkg::VAL_W'(0) - (ecse_pkg::VAL_W'(s2_c_r) + ecse_pkg::VAL_W'(s2_d_r));
    val_in[2] = ecse_pkg::VAL_W'(s2_b_r);
    val_in[3] = ecse_pkg::VAL_W'(s2_d_r);
    val_in[4] = ecse_pkg::VAL_W'(s2_a_r);
    val_in[5] = ecse_pkg::VAL_W'(s2_c_r);
    val_in[6] = pos_e;
    val_in[7] = neg_e;
    val_in[8] = neg_e;
    val_in[9] = pos_e;

    mask_in = {s2_nbr_r.left  && s2_nbr_r.up,
               s2_nbr_r.left  && s2_nbr_r.down,
               s2_nbr_r.right && s2_nbr_r.up,
               s2_nbr_r.right && s2_nbr_r.down,
               s2_nbr_r.right, s2_nbr_r.right,
               s2_nbr_r.down,  s2_nbr_r.down,
               1'b1, 1'b1};
  end

  // Serializer: hold one point, hand out its lowest pending entry each cycle that out_load is high
  ecse_pkg::idx_t ser_u_r, ser_v_r;
  ecse_pkg::idx_t ser_col_r [ecse_pkg::NUM_ENT];
  ecse_pkg::val_t ser_val_r [ecse_pkg::NUM_ENT];
  logic [3:0]                   sel;
  logic [ecse_pkg::NUM_ENT-1:0] sel_oh;

  always_comb begin
    sel    = 4'd0;
    sel_oh = '0;
    for (int k = ecse_pkg::NUM_ENT - 1; k >= 0; k--) begin
      if (ser_mask_r[k]) begin
        sel = 4'(k);
      end
    end
    sel_oh[sel] = ser_busy;
  end

  always_comb begin
    ser_mask_nxt = ser_mask_r;
    if (out_load) begin
      ser_mask_nxt = ser_mask_r & ~sel_oh;
    end
    if (ser_take) begin
      ser_mask_nxt = s2_v_r ? mask_in : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_mask_r <= '0;
    end else begin
      ser_mask_r <= ser_mask_nxt;
    end
    if (ser_take && s2_v_r) begin
      ser_u_r   <= u_idx;
      ser_v_r   <= v_idx;
      ser_col_r <= col_in;
      ser_val_r <= val_in;
    end
  end

  // Output register
  ecse_pkg::idx_t out_row_r, out_col_r;
  ecse_pkg::val_t out_val_r;
  logic           out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= ser_busy;
    end
    if (out_load && ser_busy) begin
      // The v diagonal, v down and v right entries sit in the v block row.
      out_row_r  <= (sel == 4'd1 || sel == 4'd3 || sel == 4'd5) ? ser_v_r : ser_u_r;
      out_col_r  <= ser_col_r[sel];
      out_val_r  <= ser_val_r[sel];
      out_last_r <= ser_single;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.matrix_row  = out_row_r;
  assign out_ch.matrix_col  = out_col_r;
  assign out_ch.coeff_value = out_val_r;
  assign out_ch.last_entry  = out_last_r;

endmodule

[src/ecse_checker.sv]
module ecse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ecse_pkg::IDX_W-1:0]  out_row,
  input logic [ecse_pkg::IDX_W-1:0]  out_col,
  input logic signed [ecse_pkg::VAL_W-1:0] out_value,
  input logic                        out_last
);

  // Stalled entry holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Diagonal entries are minus a sum of nonnegative products.
  a_diag_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row == out_col) |-> (out_value[ecse_pkg::VAL_W-1] || (out_value == '0)))
    else $error("positive diagonal entry");

  // An off-diagonal entry is never the first of a point, so the one before it was no last.
  a_offdiag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !(out_valid && (out_row != out_col)))
    else $error("point started with an off-diagonal entry");

endmodule

bind elasticity_stencil_coeff_emitter ecse_checker u_ecse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.matrix_row),
  .out_col   (out_ch.matrix_col),
  .out_value (out_ch.coeff_value),
  .out_last  (out_ch.last_entry)
);
